// ----- design/blecrc_pkg.sv -----
package blecrc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CRC_W      = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned HELD_DEPTH = 3;
	localparam int unsigned CNT_W      = 2;
	localparam int unsigned PHASE_W    = 2;

	localparam logic [CRC_W-1:0]  CRC_POLY     = 24'h00065B;
	localparam logic [CRC_W-1:0]  CRC_INIT_RST = 24'h555555;
	localparam logic [BYTE_W-1:0] WHITEN_TAPS  = 8'h11;
	localparam logic [BYTE_W-1:0] SEED_RST     = 8'h00;
	localparam logic              DIR_RST      = 1'b0;

	localparam logic [CNT_W-1:0]   HELD_FULL  = 2'd3;
	localparam logic [CNT_W-1:0]   HELD_TWO   = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION   = 2'd0,
		REG_WHITEN_SEED = 2'd1,
		REG_CRC_INIT    = 2'd2
	} reg_idx_t;

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	typedef struct packed {
		logic              direction;
		logic [BYTE_W-1:0] whiten_seed;
		logic [CRC_W-1:0]  crc_init;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] lfsr;
		logic [BYTE_W-1:0] data;
	} whiten_t;

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	// lfsr steps once per bit, lsb of the byte first
	function automatic whiten_t whiten(input logic [BYTE_W-1:0] lfsr,
			input logic [BYTE_W-1:0] d);
		whiten_t w;
		w.lfsr = lfsr;
		w.data = d;
		for (int i = 0; i < BYTE_W; i++) begin
			if (w.lfsr[BYTE_W-1]) begin
				w.lfsr    = w.lfsr ^ WHITEN_TAPS;
				w.data[i] = ~w.data[i];
			end
			w.lfsr = {w.lfsr[BYTE_W-2:0], 1'b0};
		end
		return w;
	endfunction

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] c;
		logic             top;
		c = crc;
		for (int i = 0; i < BYTE_W; i++) begin
			top = c[CRC_W-1];
			c   = {c[CRC_W-2:0], 1'b0};
			if (top != d[i]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic crc_match(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] r0, input logic [BYTE_W-1:0] r1,
			input logic [BYTE_W-1:0] r2);
		return (crc[23:16] == rev8(r0)) && (crc[15:8] == rev8(r1)) &&
			(crc[7:0] == rev8(r2));
	endfunction

endpackage

// ----- design/blecrc_byte_if.sv -----
interface blecrc_byte_if;
	import blecrc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_in;
	logic              last_in;

	modport source(output valid, data_in, last_in, input ready);
	modport sink(input valid, data_in, last_in, output ready);
endinterface

// ----- design/blecrc_res_if.sv -----
interface blecrc_res_if;
	import blecrc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_out;
	logic              last_out;
	logic              crc_ok;

	modport source(output valid, data_out, last_out, crc_ok, input ready);
	modport sink(input valid, data_out, last_out, crc_ok, output ready);
endinterface

// ----- design/blecrc_cfg_if.sv -----
interface blecrc_cfg_if;
	import blecrc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CRC_W-1:0]     wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ----- design/blecrc_cfg_regs.sv -----
module blecrc_cfg_regs
	import blecrc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	blecrc_cfg_if.sink   cfg_ch,
	output cfg_t         cfg
);

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= DIR_RST;
			cfg_q.whiten_seed <= SEED_RST;
			cfg_q.crc_init    <= CRC_INIT_RST;
		end else if (cfg_ch.valid) begin
			case (reg_idx_t'(cfg_ch.index))
				REG_DIRECTION:   cfg_q.direction   <= cfg_ch.wdata[0];
				REG_WHITEN_SEED: cfg_q.whiten_seed <= cfg_ch.wdata[BYTE_W-1:0];
				REG_CRC_INIT:    cfg_q.crc_init    <= cfg_ch.wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/blecrc_in_stage.sv -----
module blecrc_in_stage
	import blecrc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	blecrc_byte_if.sink  byte_ch,
	input  logic         release_s1,
	output logic         valid_s1,
	output item_t        item_s1
);

	logic take;

	// a slot frees in the same cycle the engine retires the held item
	assign byte_ch.ready = !valid_s1 || release_s1;
	assign take          = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data <= byte_ch.data_in;
			item_s1.last <= byte_ch.last_in;
		end
	end

endmodule

// ----- design/blecrc_engine.sv -----
module blecrc_engine
	import blecrc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          valid_s1,
	input  item_t         item_s1,
	output logic          release_s1,
	blecrc_res_if.source  res_ch
);

	logic               pkt_open_q;
	dir_t               dir_q;
	logic [CRC_W-1:0]   crc_q;
	logic [BYTE_W-1:0]  lfsr_q;
	logic [BYTE_W-1:0]  held_q [HELD_DEPTH];
	logic [CNT_W-1:0]   cnt_q;
	logic [PHASE_W-1:0] phase_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic               out_last_q;
	logic               out_ok_q;

	dir_t               dir_c;
	logic [CRC_W-1:0]   crc_c;
	logic [BYTE_W-1:0]  lfsr_c;
	logic [CNT_W-1:0]   cnt_c;

	logic               fire;
	logic               done;
	logic               emit;
	logic [BYTE_W-1:0]  res_data;
	logic               res_last;
	logic               res_ok;
	logic [CRC_W-1:0]   crc_n;
	logic [BYTE_W-1:0]  lfsr_n;
	logic [CNT_W-1:0]   cnt_n;
	logic               shift_held;
	logic               store_held;
	logic [BYTE_W-1:0]  crc_sel;
	logic [CRC_W-1:0]   crc_tail;
	whiten_t            wh;

	// the first byte of a packet picks up the configuration
	assign dir_c  = pkt_open_q ? dir_q  : dir_t'(cfg.direction);
	assign crc_c  = pkt_open_q ? crc_q  : cfg.crc_init;
	assign lfsr_c = pkt_open_q ? lfsr_q : cfg.whiten_seed;
	assign cnt_c  = pkt_open_q ? cnt_q  : '0;

	assign fire       = valid_s1 && (!out_valid_q || res_ch.ready);
	assign release_s1 = fire && done;

	always_comb begin
		crc_sel = crc_c[23:16];
		case (phase_q)
			2'd1:    crc_sel = crc_c[23:16];
			2'd2:    crc_sel = crc_c[15:8];
			2'd3:    crc_sel = crc_c[7:0];
			default: crc_sel = crc_c[23:16];
		endcase
	end

	always_comb begin
		done       = 1'b1;
		emit       = 1'b0;
		res_data   = '0;
		res_last   = 1'b0;
		res_ok     = 1'b0;
		crc_n      = crc_c;
		cnt_n      = cnt_c;
		shift_held = 1'b0;
		store_held = 1'b0;
		crc_tail   = crc_byte(crc_c, held_q[0]);
		wh         = whiten(lfsr_c, rev8(item_s1.data));
		case (dir_c)
			DIR_ENCODE: begin
				emit = 1'b1;
				if (phase_q == '0) begin
					crc_n    = crc_byte(crc_c, item_s1.data);
					wh       = whiten(lfsr_c, item_s1.data);
					res_data = rev8(wh.data);
					done     = !item_s1.last;
				end else begin
					// appended crc bytes, high byte first, one per cycle unless the result channel stalls
					wh       = whiten(lfsr_c, rev8(crc_sel));
					res_data = rev8(wh.data);
					res_last = (phase_q == PHASE_LAST);
					done     = (phase_q == PHASE_LAST);
				end
			end
			DIR_DECODE: begin
				if (!item_s1.last) begin
					if (cnt_c == HELD_FULL) begin
						emit       = 1'b1;
						res_data   = held_q[0];
						crc_n      = crc_tail;
						shift_held = 1'b1;
					end else begin
						store_held = 1'b1;
						cnt_n      = cnt_c + 1'b1;
					end
				end else begin
					emit     = 1'b1;
					res_last = 1'b1;
					if (cnt_c == HELD_FULL) begin
						res_data = held_q[0];
						res_ok   = crc_match(crc_tail, held_q[1], held_q[2], wh.data);
					end else if (cnt_c == HELD_TWO) begin
						// empty payload: received crc against the initial value
						res_ok = crc_match(crc_c, held_q[0], held_q[1], wh.data);
					end
				end
			end
			default: begin
			end
		endcase
		lfsr_n = wh.lfsr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_open_q  <= 1'b0;
			dir_q       <= DIR_ENCODE;
			cnt_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pkt_open_q <= !(done && item_s1.last);
				dir_q      <= dir_c;
				cnt_q      <= cnt_n;
				phase_q    <= done ? '0 : phase_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= emit;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			crc_q  <= crc_n;
			lfsr_q <= lfsr_n;
			if (shift_held) begin
				held_q[0] <= held_q[1];
				held_q[1] <= held_q[2];
				held_q[2] <= wh.data;
			end else if (store_held) begin
				held_q[cnt_c] <= wh.data;
			end
			if (emit) begin
				out_data_q <= res_data;
				out_last_q <= res_last;
				out_ok_q   <= res_ok;
			end
		end
	end

	assign res_ch.valid    = out_valid_q;
	assign res_ch.data_out = out_data_q;
	assign res_ch.last_out = out_last_q;
	assign res_ch.crc_ok   = out_ok_q;

endmodule

// ----- design/ble_link_layer_crc_whitening_codec_core.sv -----
// CRC-24 and whitening codec for advertising packets on a byte radio. One byte item is taken
// per clock unless the engine stalls; a result is computed from the input register and leaves
// through a result register, so the next byte is accepted while a result waits. Encode gives
// one air byte per payload byte; the byte marked last occupies the engine for four results,
// its own and the three CRC bytes, which pass one at a time through the whitening unit. Decode
// holds back the last three air bytes as the received CRC and gives zero or one result per
// byte; the final result carries last_out and crc_ok. direction, whiten_seed and crc_init are
// latched at the first byte of each packet. There is no start-up pass after reset.
module ble_link_layer_crc_whitening_codec_core
	import blecrc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	blecrc_byte_if.sink   byte_ch,
	blecrc_res_if.source  res_ch,
	blecrc_cfg_if.sink    cfg_ch
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  release_s1;

	blecrc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	blecrc_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.release_s1 (release_s1),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	blecrc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.release_s1 (release_s1),
		.res_ch     (res_ch)
	);

endmodule
